>>> hdl/shbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbw_pkg
// Shared constants, types and table generation for the smoothed histogram
// bin weight block.
// ----------------------------------------------------------------------------
package shbw_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 256;

  localparam logic [31:0] INV_SQRT2_Q32       = 32'd3037000500;
  localparam logic [31:0] INV_SQRT2PI_Q32     = 32'd1713444046;
  localparam logic [31:0] TWO_OVER_SQRTPI_Q31 = 32'd2423175810;

  // configuration register indexes
  localparam logic [2:0] REG_KERNEL_TYPE   = 3'd0;
  localparam logic [2:0] REG_APPLY_CUTOFF  = 3'd1;
  localparam logic [2:0] REG_PERIODIC      = 3'd2;
  localparam logic [2:0] REG_LOWER_BOUND   = 3'd3;
  localparam logic [2:0] REG_UPPER_BOUND   = 3'd4;
  localparam logic [2:0] REG_INV_WIDTH     = 3'd5;
  localparam logic [2:0] REG_PERIOD_LENGTH = 3'd6;
  localparam logic [2:0] REG_INV_PERIOD    = 3'd7;

  typedef struct packed {
    logic        big;
    logic [15:0] frac;
    logic [16:0] erf_a;
    logic [16:0] erf_b;
    logic [16:0] exp_a;
    logic [16:0] exp_b;
  } rom_out_t;

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  // shift and subtract quotient, table generation only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = 64'd0;
    r = 65'd0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // table point i of erf(t) or exp(-t^2), t = 4*i/depth, Q16
  function automatic logic [16:0] rom_entry(input int i, input int depth,
                                            input logic want_erf);
    logic [63:0] t, y, term, e, s, r, q;
    logic        done;
    int          n, k;
    t = div_u64(64'(i) << 38, 64'(depth));
    y = mul_shr(t, t, 36);
    term = 64'd1 << 36;
    e = term;
    done = 1'b0;
    for (n = 1; n < 200; n++) begin
      if (!done) begin
        term = div_u64(mul_shr(term, y, 36), 64'(n));
        if (term == 64'd0) done = 1'b1;
        else e = e + term;
      end
    end
    term = t;
    s = t;
    done = 1'b0;
    for (n = 1; n < 300; n++) begin
      if (!done) begin
        term = div_u64(mul_shr(term, y << 1, 36), 64'(2 * n + 1));
        if (term == 64'd0) done = 1'b1;
        else s = s + term;
      end
    end
    if (!want_erf) return 17'(div_u64((64'd1 << 52) + (e >> 1), e));
    r = (s >= e) ? e - 64'd1 : s;
    q = 64'd0;
    for (k = 0; k < 32; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= e) begin
        r = r - e;
        q[0] = 1'b1;
      end
    end
    q = (q * 64'(TWO_OVER_SQRTPI_Q31) + (64'd1 << 46)) >> 47;
    if (q > 64'd65536) q = 64'd65536;
    return 17'(q);
  endfunction

endpackage

>>> hdl/shbw_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbw_rom
// erf and gaussian tables with index and fraction split for interpolation.
// ----------------------------------------------------------------------------
module shbw_rom #(
  parameter int TABLE_DEPTH = shbw_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic [23:0]        t,
  output shbw_pkg::rom_out_t look
);
  import shbw_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = 18 + IW;

  logic [16:0]   erf_rom [0:TABLE_DEPTH];
  logic [16:0]   exp_rom [0:TABLE_DEPTH];
  logic [PW-1:0] pos;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx1;

  for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_rom
    localparam logic [16:0] ERF_V = rom_entry(g, TABLE_DEPTH, 1'b1);
    localparam logic [16:0] EXP_V = rom_entry(g, TABLE_DEPTH, 1'b0);
    assign erf_rom[g] = ERF_V;
    assign exp_rom[g] = EXP_V;
  end

  assign pos  = PW'(t[17:0]) * PW'(TABLE_DEPTH);
  assign idx  = pos[PW-1:18];
  assign idx1 = idx + IW'(1);

  always_comb begin
    look.big   = (t >= 24'd262144);
    look.frac  = pos[17:2];
    look.erf_a = erf_rom[idx];
    look.erf_b = erf_rom[idx1];
    look.exp_a = exp_rom[idx];
    look.exp_b = exp_rom[idx1];
  end

endmodule

>>> hdl/smoothed_histogram_bin_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_histogram_bin_weight
// Smoothed membership weight of a sample in one bin and its slope, gaussian
// or triangular kernel, optional periodic wrap and cutoff.
//
//   channel   direction  handshake                     payload
//   sample    in         sample_valid / sample_stall   sample
//   result    out        result_valid / result_stall   weight, slope
//   config    in         cfg_write                     cfg_index, cfg_data
//
// one transaction per cycle sustained unless the result stalls, through the
// nine register stages (wrap, difference, scale, table address, table read,
// interpolation, weight, two slope product stages)
// synchronous reset clears the valid bits and presets the config registers
// a stalled result holds; stages behind it keep filling bubbles
// ----------------------------------------------------------------------------
module smoothed_histogram_bin_weight #(
  parameter int TABLE_DEPTH = shbw_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [31:0] sample,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [16:0]        weight,
  output logic signed [31:0] slope
);
  import shbw_pkg::*;

  localparam int STAGES = 9;

  function automatic logic signed [25:0] scale_z(input logic signed [32:0] d,
                                                 input logic [31:0] iw);
    logic [32:0] m;
    logic [64:0] p;
    logic [48:0] r;
    logic [24:0] rs;
    m  = d[32] ? 33'(-d) : 33'(d);
    p  = 65'(m) * 65'(iw);
    r  = p[64:16];
    rs = (r > 49'd16777216) ? 25'd16777216 : r[24:0];
    return d[32] ? -$signed({1'b0, rs}) : $signed({1'b0, rs});
  endfunction

  function automatic logic [23:0] t_of(input logic signed [25:0] z);
    logic [24:0] mag;
    logic [56:0] p;
    mag = z[25] ? 25'(-z) : z[24:0];
    p   = 57'(mag) * 57'(INV_SQRT2_Q32) + 57'(32'h8000_0000);
    return p[55:32];
  endfunction

  function automatic logic signed [17:0] clamp_one(input logic signed [25:0] z);
    if (z < -26'sd65536) return -18'sd65536;
    if (z > 26'sd65536) return 18'sd65536;
    return z[17:0];
  endfunction

  function automatic logic [16:0] n_part(input logic signed [25:0] z);
    logic [24:0] a;
    a = z[25] ? 25'(-z) : z[24:0];
    return (a < 25'd65536) ? 17'(25'd65536 - a) : 17'd0;
  endfunction

  function automatic logic signed [36:0] tri_prim(input logic signed [17:0] v);
    logic [17:0]        a;
    logic signed [36:0] vs, ks;
    a  = v[17] ? 18'(-v) : v;
    vs = 37'(v);
    ks = 37'sd131072 - $signed(37'(a));
    return vs * ks;
  endfunction

  function automatic logic [16:0] interp(input logic [16:0] a, input logic [16:0] b,
                                         input logic [15:0] fr);
    logic signed [35:0] d, s;
    d = $signed(36'(b)) - $signed(36'(a));
    s = d * $signed(36'(fr)) + 36'sd32768;
    return 17'($signed(36'(a)) + (s >>> 16));
  endfunction

  function automatic logic signed [31:0] sat32(input logic neg, input logic [33:0] mag);
    if (neg) begin
      if (mag > 34'h0_8000_0000) return 32'sh8000_0000;
      return 32'(~mag + 34'd1);
    end
    if (mag > 34'h0_7fff_ffff) return 32'sh7fff_ffff;
    return mag[31:0];
  endfunction

  // configuration
  logic               kernel_type;
  logic               apply_cutoff;
  logic               periodic;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic [31:0]        inv_width;
  logic [30:0]        period_length;
  logic [31:0]        inv_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_type   <= 1'b0;
      apply_cutoff  <= 1'b0;
      periodic      <= 1'b0;
      lower_bound   <= 32'sd0;
      upper_bound   <= 32'sd65536;
      inv_width     <= 32'd131072;
      period_length <= 31'd65536;
      inv_period    <= 32'd65536;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KERNEL_TYPE:   kernel_type   <= cfg_data[0];
        REG_APPLY_CUTOFF:  apply_cutoff  <= cfg_data[0];
        REG_PERIODIC:      periodic      <= cfg_data[0];
        REG_LOWER_BOUND:   lower_bound   <= cfg_data;
        REG_UPPER_BOUND:   upper_bound   <= cfg_data;
        REG_INV_WIDTH:     inv_width     <= cfg_data;
        REG_PERIOD_LENGTH: period_length <= cfg_data[30:0];
        REG_INV_PERIOD:    inv_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control
  logic [STAGES:1]   vld;
  logic [STAGES+1:1] adv;

  always_comb begin
    adv[STAGES+1] = !result_stall;
    for (int k = STAGES; k >= 1; k--) adv[k] = !vld[k] || adv[k+1];
  end

  assign sample_stall = !adv[1];
  assign result_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= sample_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: periodic fraction
  logic [31:0]        s_abs;
  logic [63:0]        w_prod;
  logic signed [31:0] x1, f1;

  assign s_abs  = sample[31] ? 32'(-sample) : sample;
  assign w_prod = 64'(s_abs) * 64'(inv_period);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x1 <= sample;
      f1 <= sample[31] ? 32'(-w_prod[31:0]) : w_prod[31:0];
    end
  end

  // stage 2: wrapped sample and distances to the edges
  logic signed [63:0] f_prod;
  logic signed [31:0] x_sel;
  logic signed [32:0] dl2, du2;

  assign f_prod = 64'(f1) * $signed({33'd0, period_length}) + 64'sd2147483648;
  assign x_sel  = periodic ? $signed(f_prod[63:32]) : x1;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dl2 <= 33'(lower_bound) - 33'(x_sel);
      du2 <= 33'(upper_bound) - 33'(x_sel);
    end
  end

  // stage 3: scaled distances
  logic signed [25:0] zl3, zu3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      zl3 <= scale_z(dl2, inv_width);
      zu3 <= scale_z(du2, inv_width);
    end
  end

  // stage 4: cutoff, table argument, triangle terms
  logic signed [25:0] cut_c;
  logic signed [17:0] n_diff;
  logic               cut4, negl4, negu4, tri_on4, nneg4;
  logic [23:0]        tl4, tu4;
  logic [16:0]        nabs4;
  logic signed [17:0] ia4, ib4;

  assign cut_c  = kernel_type ? 26'sd65536 : 26'sd231704;
  assign n_diff = $signed({1'b0, n_part(zl3)}) - $signed({1'b0, n_part(zu3)});

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      cut4    <= apply_cutoff && (zu3 <= -cut_c || zl3 >= cut_c);
      negl4   <= zl3[25];
      negu4   <= zu3[25];
      tl4     <= t_of(zl3);
      tu4     <= t_of(zu3);
      tri_on4 <= !(zu3 <= -26'sd65536 || zl3 >= 26'sd65536);
      nneg4   <= n_diff[17];
      nabs4   <= n_diff[17] ? 17'(-n_diff) : n_diff[16:0];
      ia4     <= clamp_one(zl3);
      ib4     <= clamp_one(zu3);
    end
  end

  // stage 5: table read
  rom_out_t           look_l, look_u, rl5, ru5;
  logic [48:0]        tm_prod;
  logic               cut5, negl5, negu5, tri_on5, nneg5;
  logic [32:0]        mt5;
  logic signed [36:0] pa5, pb5;

  shbw_rom #(.TABLE_DEPTH(TABLE_DEPTH)) u_rom_l (.t(tl4), .look(look_l));
  shbw_rom #(.TABLE_DEPTH(TABLE_DEPTH)) u_rom_u (.t(tu4), .look(look_u));

  assign tm_prod = 49'(nabs4) * 49'(inv_width);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      rl5     <= look_l;
      ru5     <= look_u;
      cut5    <= cut4;
      negl5   <= negl4;
      negu5   <= negu4;
      tri_on5 <= tri_on4;
      nneg5   <= nneg4;
      mt5     <= tm_prod[48:16];
      pa5     <= tri_prim(ia4);
      pb5     <= tri_prim(ib4);
    end
  end

  // stage 6: interpolation, triangle results
  logic [16:0]        evl, evu;
  logic signed [37:0] tq;
  logic signed [37:0] tw;
  logic               cut6;
  logic signed [17:0] el6, eu6;
  logic [16:0]        xl6, xu6;
  logic [16:0]        wt6;
  logic signed [31:0] st6;

  assign evl = rl5.big ? 17'd65536 : interp(rl5.erf_a, rl5.erf_b, rl5.frac);
  assign evu = ru5.big ? 17'd65536 : interp(ru5.erf_a, ru5.erf_b, ru5.frac);
  assign tq  = 38'(pb5) - 38'(pa5) + 38'sd65536;
  assign tw  = tq >>> 17;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      cut6 <= cut5;
      el6  <= negl5 ? -$signed({1'b0, evl}) : $signed({1'b0, evl});
      eu6  <= negu5 ? -$signed({1'b0, evu}) : $signed({1'b0, evu});
      xl6  <= rl5.big ? 17'd0 : interp(rl5.exp_a, rl5.exp_b, rl5.frac);
      xu6  <= ru5.big ? 17'd0 : interp(ru5.exp_a, ru5.exp_b, ru5.frac);
      st6  <= sat32(nneg5, 34'(mt5));
      if (!tri_on5 || tw < 38'sd0) wt6 <= 17'd0;
      else if (tw > 38'sd65536)    wt6 <= 17'd65536;
      else                         wt6 <= tw[16:0];
    end
  end

  // stage 7: gaussian weight, slope magnitude
  logic signed [18:0] e_diff, x_diff;
  logic [17:0]        e_clip;
  logic [16:0]        x_abs;
  logic               cut7, sneg7;
  logic [16:0]        wg7, wt7;
  logic signed [31:0] st7;
  logic [48:0]        mg7;

  assign e_diff = 19'(eu6) - 19'(el6);
  assign e_clip = (e_diff < 19'sd0) ? 18'd0 :
                  (e_diff > 19'sd131072) ? 18'd131072 : e_diff[17:0];
  assign x_diff = $signed({2'b0, xl6}) - $signed({2'b0, xu6});
  assign x_abs  = x_diff[18] ? 17'(-x_diff) : x_diff[16:0];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      cut7  <= cut6;
      wg7   <= 17'((19'(e_clip) + 19'd1) >> 1);
      sneg7 <= x_diff[18];
      mg7   <= 49'(x_abs) * 49'(inv_width);
      wt7   <= wt6;
      st7   <= st6;
    end
  end

  // stage 8: slope partial products
  logic               cut8, sneg8;
  logic [16:0]        wg8, wt8;
  logic signed [31:0] st8;
  logic [56:0]        pl8;
  logic [55:0]        ph8;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      cut8  <= cut7;
      sneg8 <= sneg7;
      wg8   <= wg7;
      wt8   <= wt7;
      st8   <= st7;
      pl8   <= 57'(mg7[24:0]) * 57'(INV_SQRT2PI_Q32);
      ph8   <= 56'(mg7[48:25]) * 56'(INV_SQRT2PI_Q32);
    end
  end

  // stage 9: result register
  logic [81:0]        tot;
  logic signed [31:0] sg;

  assign tot = 82'({ph8, 25'd0}) + 82'(pl8);
  assign sg  = sat32(sneg8, tot[81:48]);

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      if (cut8) begin
        weight <= 17'd0;
        slope  <= 32'sd0;
      end else if (kernel_type) begin
        weight <= wt8;
        slope  <= st8;
      end else begin
        weight <= wg8;
        slope  <= sg;
      end
    end
  end

endmodule

>>> hdl/shbw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbw_checker
// Port-level checks for the smoothed histogram bin weight block.
// ----------------------------------------------------------------------------
module shbw_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic [16:0]        weight,
  input logic signed [31:0] slope
);

  // weight never exceeds one
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> weight <= 17'd65536)
    else $error("weight above one");

  // nothing in flight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // an empty output stage never stalls the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !sample_stall)
    else $error("input stalled with empty output");

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(weight) && $stable(slope))
    else $error("stalled result changed");

endmodule

bind smoothed_histogram_bin_weight shbw_checker u_shbw_checker (.*);

>>> sim/smoothed_histogram_bin_weight_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_histogram_bin_weight_test
// Self-checking bench for the bin weight block: a directed table at reset
// settings and at the corner settings, then random bins and samples over
// both kernels, cutoff and periodic wrap, with sender gaps, receiver stalls
// and one long receiver hold-off. Each result is checked against a local
// fixed point predictor of weight and slope or a typed expected value.
// ----------------------------------------------------------------------------
module smoothed_histogram_bin_weight_test;
  import shbw_pkg::*;

  localparam int     DEPTH     = TABLE_DEPTH_DEFAULT;
  localparam longint ONE       = 64'sd65536;
  localparam longint HALF32    = 64'sd2147483648;
  localparam longint Z_SAT     = 64'sd16777216;
  localparam longint G_CUT     = 64'sd231704;
  localparam int     WDOG_MAX  = 5000;

  typedef struct packed {
    logic [16:0] w;
    logic [31:0] s;
  } bin_res_t;

  typedef struct {
    logic [31:0] x;
    bit          typed;
    logic [16:0] w;
    logic [31:0] s;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = REG_KERNEL_TYPE;
  logic [31:0] cfg_data = '0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic signed [31:0] sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [16:0] weight;
  logic signed [31:0] slope;

  // predictor copy of the registers
  bit     kern_tri = 0, cut_on = 0, wrap_on = 0;
  longint lo_b = 0, up_b = 65536, iw = 131072, per_len = 65536, inv_per = 65536;
  longint erf_tab [0:DEPTH];
  longint gexp_tab[0:DEPTH];

  bin_res_t pending_q[$];
  int  n_errors = 0;
  int  send_idle = 0, stall_pct = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  smoothed_histogram_bin_weight uut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall, .weight, .slope
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] mulsh(input logic [63:0] a, input logic [63:0] b,
                                        input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint to_z(input longint d);
    logic [127:0] p;
    longint m, r;
    m = d < 0 ? -d : d;
    p = (128'(m) * 128'(iw)) >> 16;
    r = (p > 128'(Z_SAT)) ? Z_SAT : longint'(p[63:0]);
    return d < 0 ? -r : r;
  endfunction

  function automatic void gauss_pt(input longint z, output longint ev, output longint xv);
    longint mag, t, p, i, fr;
    mag = z < 0 ? -z : z;
    t = (mag * longint'(INV_SQRT2_Q32) + HALF32) >>> 32;
    if (t >= 4 * ONE) begin
      ev = ONE;
      xv = 0;
    end else begin
      p = t * DEPTH;
      i = p >>> 18;
      fr = (p >>> 2) & 64'sd65535;
      ev = erf_tab[i] + (((erf_tab[i+1] - erf_tab[i]) * fr + 32768) >>> 16);
      xv = gexp_tab[i] + (((gexp_tab[i+1] - gexp_tab[i]) * fr + 32768) >>> 16);
    end
    if (z < 0) ev = -ev;
  endfunction

  function automatic longint tri_area(input longint v);
    return v * (2 * ONE - (v < 0 ? -v : v));
  endfunction

  function automatic bin_res_t predict_bin(input logic [31:0] xin);
    bin_res_t r;
    longint x, f, zl, zu, w, sl, el, xl, eu, xu, diff, al, au, n, ia, ib;
    logic [63:0] prod, u, m;
    x = longint'(signed'(xin));
    w = 0;
    if (wrap_on) begin
      prod = 64'(x < 0 ? -x : x) * 64'(inv_per);
      u = (x < 0) ? (64'd0 - prod) : prod;
      u = u + 64'd2147483648;
      f = longint'({32'd0, u[31:0]}) - HALF32;
      x = (f * per_len + HALF32) >>> 32;
    end
    zl = to_z(lo_b - x);
    zu = to_z(up_b - x);
    if (cut_on && (zu <= -(kern_tri ? ONE : G_CUT) || zl >= (kern_tri ? ONE : G_CUT))) begin
      r.w = '0;
      r.s = '0;
      return r;
    end
    if (!kern_tri) begin
      gauss_pt(zl, el, xl);
      gauss_pt(zu, eu, xu);
      diff = eu - el;
      if (diff < 0) diff = 0;
      if (diff > 2 * ONE) diff = 2 * ONE;
      w = (diff + 1) >>> 1;
      diff = xl - xu;
      m = 64'(diff < 0 ? -diff : diff) * 64'(iw);
      m = mulsh(m, 64'(INV_SQRT2PI_Q32), 48);
      sl = sat32(diff < 0 ? -longint'(m) : longint'(m));
    end else begin
      al = zl < 0 ? -zl : zl;
      au = zu < 0 ? -zu : zu;
      n = 0;
      if (al < ONE) n = ONE - al;
      if (au < ONE) n = n - (ONE - au);
      m = (64'(n < 0 ? -n : n) * 64'(iw)) >> 16;
      sl = sat32(n < 0 ? -longint'(m) : longint'(m));
      if (!(zu <= -ONE || zl >= ONE)) begin
        ia = zl > -ONE ? zl : -ONE;
        ib = zu < ONE ? zu : ONE;
        w = (tri_area(ib) - tri_area(ia) + 65536) >>> 17;
        if (w < 0) w = 0;
        if (w > ONE) w = ONE;
      end
    end
    r.w = 17'(w);
    r.s = 32'(sl);
    return r;
  endfunction

  // erf(t) and exp(-t^2) table points, series evaluated in Q36
  initial begin
    logic [63:0] t, y, term, e, s, r, q;
    bit done;
    for (int i = 0; i <= DEPTH; i++) begin
      t = (64'(i) << 38) / 64'(DEPTH);
      y = mulsh(t, t, 36);
      term = 64'd1 << 36;
      e = term;
      done = 0;
      for (int n = 1; n < 200 && !done; n++) begin
        term = mulsh(term, y, 36) / 64'(n);
        if (term == 0) done = 1;
        else e = e + term;
      end
      term = t;
      s = t;
      done = 0;
      for (int n = 1; n < 300 && !done; n++) begin
        term = mulsh(term, y << 1, 36) / 64'(2 * n + 1);
        if (term == 0) done = 1;
        else s = s + term;
      end
      gexp_tab[i] = longint'(((64'd1 << 52) + e / 2) / e);
      r = (s >= e) ? e - 1 : s;
      q = 0;
      for (int k = 0; k < 32; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= e) begin
          r = r - e;
          q[0] = 1'b1;
        end
      end
      q = (q * 64'(TWO_OVER_SQRTPI_Q31) + (64'd1 << 46)) >> 47;
      erf_tab[i] = (q > 64'd65536) ? ONE : longint'(q);
    end
  end

  // result checking
  always @(posedge clk) begin
    bin_res_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: weight %0d slope %0d", weight, slope);
        n_errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (weight !== exp_r.w) begin
          $error("weight: expected %0d, got %0d", exp_r.w, weight);
          n_errors++;
        end
        if (slope !== exp_r.s) begin
          $error("slope: expected %0d, got %0d", signed'(exp_r.s), slope);
          n_errors++;
        end
      end
    end
  end

  // receiver stalls and hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_KERNEL_TYPE:   kern_tri = val[0];
      REG_APPLY_CUTOFF:  cut_on = val[0];
      REG_PERIODIC:      wrap_on = val[0];
      REG_LOWER_BOUND:   lo_b = longint'(signed'(val));
      REG_UPPER_BOUND:   up_b = longint'(signed'(val));
      REG_INV_WIDTH:     iw = longint'({32'd0, val});
      REG_PERIOD_LENGTH: per_len = longint'({33'd0, val[30:0]});
      REG_INV_PERIOD:    inv_per = longint'({32'd0, val});
      default: ;
    endcase
  endtask

  task automatic set_bin(input bit kt, input bit ct, input bit pr, input logic [31:0] lo,
                         input logic [31:0] up, input logic [31:0] inw,
                         input logic [31:0] pl, input logic [31:0] ip);
    sample_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    // upper bits of the narrow registers carry noise
    reg_write(REG_KERNEL_TYPE, {$urandom} & 32'hffff_fffe | 32'(kt));
    reg_write(REG_APPLY_CUTOFF, {$urandom} & 32'hffff_fffe | 32'(ct));
    reg_write(REG_PERIODIC, {$urandom} & 32'hffff_fffe | 32'(pr));
    reg_write(REG_LOWER_BOUND, lo);
    reg_write(REG_UPPER_BOUND, up);
    reg_write(REG_INV_WIDTH, inw);
    reg_write(REG_PERIOD_LENGTH, pl);
    reg_write(REG_INV_PERIOD, ip);
    cfg_write <= 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] x, input bit typed,
                             input logic [16:0] w, input logic [31:0] s);
    while ($urandom_range(0, 99) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= x;
    do @(posedge clk); while (sample_stall);
    pending_q = {pending_q, (typed ? bin_res_t'({w, s}) : predict_bin(x))};
  endtask

  initial begin
    dir_row_t dir_tab[10];
    logic [31:0] corner_x[2];
    logic [31:0] lo, up, inw, pl, ip;
    longint ctr, half, wd;
    bit pr;
    dir_tab = '{
      '{32'h7fff_ffff, 1, 17'd0, 32'd0},
      '{32'h8000_0000, 1, 17'd0, 32'd0},
      '{32'h0000_0000, 0, 17'd0, 32'd0},
      '{32'h0000_8000, 0, 17'd0, 32'd0},
      '{32'h0001_0000, 0, 17'd0, 32'd0},
      '{32'hffff_0000, 0, 17'd0, 32'd0},
      '{32'h0002_0000, 0, 17'd0, 32'd0},
      '{32'h0000_0001, 0, 17'd0, 32'd0},
      '{32'hffff_ffff, 0, 17'd0, 32'd0},
      '{32'h0000_4000, 0, 17'd0, 32'd0}
    };
    corner_x = '{32'h0000_6000, 32'hffff_c000};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_sample(dir_tab[i].x, dir_tab[i].typed, dir_tab[i].w, dir_tab[i].s);

    // triangular with cutoff, gaussian with cutoff, zero period, inverted bin,
    // zero inverse width, slope overflow
    for (int c = 0; c < 6; c++) begin
      case (c)
        0: set_bin(1, 1, 0, 32'h0, 32'h10000, 32'h20000, 32'h10000, 32'h10000);
        1: set_bin(0, 1, 0, 32'h0, 32'h10000, 32'h20000, 32'h10000, 32'h10000);
        2: set_bin(0, 0, 1, 32'hffff_8000, 32'h8000, 32'h20000, 32'h0, 32'hffff_ffff);
        3: set_bin(1, 0, 0, 32'h10000, 32'h0, 32'h20000, 32'h10000, 32'h10000);
        4: set_bin(0, 0, 0, 32'h0, 32'h10000, 32'h0, 32'h7fff_ffff, 32'h0);
        default: set_bin(0, 0, 0, 32'h0, 32'h1, 32'hffff_ffff, 32'h10000, 32'h10000);
      endcase
      foreach (corner_x[i]) send_sample(corner_x[i], 0, '0, '0);
    end

    for (int ph = 0; ph < 12; ph++) begin
      pr = $urandom_range(0, 2) == 0;
      case ($urandom_range(0, 5))
        0: inw = 32'hffff_ffff;
        1: inw = 32'd1;
        default: inw = $urandom_range(32'h4000, 32'h100000);
      endcase
      if (ph == 2) begin
        lo = 32'h8000_0000;
        up = 32'h7fff_ffff;
      end else begin
        lo = $urandom_range(0, 32'h100000) - 32'h80000;
        up = lo + $urandom_range(0, 32'h40000) - 32'h4000;
      end
      pl = (ph == 5) ? 32'h7fff_ffff : $urandom_range(1, 32'h400000);
      ip = (ph == 7) ? $urandom : 32'(64'h1_0000_0000_0000 / 64'(pl[30:0]));
      set_bin(ph[0] ^ ph[2], ph[1], pr, lo, up, inw, pl, ip);
      case (ph % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 52; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 52; end
        default: begin send_idle = 35; stall_pct = 35; end
      endcase
      if (ph == 0) hold_req = 1;
      wd = (iw > 0) ? (64'sd4294967296 / iw) : ONE;
      ctr = (lo_b + up_b) / 2;
      half = (up_b > lo_b ? up_b - lo_b : lo_b - up_b) / 2 + 3 * wd;
      if (half > 64'sd1073741824) half = 64'sd1073741824;
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(0, 4) == 0) send_sample($urandom, 0, '0, '0);
        else send_sample(32'(ctr - half + longint'($urandom_range(0, 32'(2 * half)))),
                         0, '0, '0);
      end
    end
    sample_valid <= 1'b0;
    stall_pct = 20;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
